### rtl/sgrd_pkg.sv
// Shared types and parameter codes for the SGR attribute decoder.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sgrd_pkg;

    localparam int unsigned PARAM_W = 16;
    localparam int unsigned ATTR_W  = 8;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned KIND_W  = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEL,
        PH_IDX,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_SKIP
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_DEFAULT = 2'd0,
        KIND_INDEXED = 2'd1,
        KIND_RGB     = 2'd2
    } t_kind;

    // Attribute flag positions
    localparam int unsigned ATTR_BOLD      = 0;
    localparam int unsigned ATTR_FAINT     = 1;
    localparam int unsigned ATTR_ITALIC    = 2;
    localparam int unsigned ATTR_UNDERLINE = 3;
    localparam int unsigned ATTR_BLINK     = 4;
    localparam int unsigned ATTR_REVERSE   = 5;
    localparam int unsigned ATTR_HIDDEN    = 6;
    localparam int unsigned ATTR_STRIKE    = 7;

    // Parameter codes
    localparam logic [PARAM_W-1:0] SGR_RESET         = 16'd0;
    localparam logic [PARAM_W-1:0] SGR_BOLD          = 16'd1;
    localparam logic [PARAM_W-1:0] SGR_FAINT         = 16'd2;
    localparam logic [PARAM_W-1:0] SGR_ITALIC        = 16'd3;
    localparam logic [PARAM_W-1:0] SGR_UNDERLINE     = 16'd4;
    localparam logic [PARAM_W-1:0] SGR_BLINK         = 16'd5;
    localparam logic [PARAM_W-1:0] SGR_REVERSE       = 16'd7;
    localparam logic [PARAM_W-1:0] SGR_HIDDEN        = 16'd8;
    localparam logic [PARAM_W-1:0] SGR_STRIKE        = 16'd9;
    localparam logic [PARAM_W-1:0] SGR_NORMAL_WEIGHT = 16'd22;
    localparam logic [PARAM_W-1:0] SGR_NO_ITALIC     = 16'd23;
    localparam logic [PARAM_W-1:0] SGR_NO_UNDERLINE  = 16'd24;
    localparam logic [PARAM_W-1:0] SGR_NO_BLINK      = 16'd25;
    localparam logic [PARAM_W-1:0] SGR_NO_REVERSE    = 16'd27;
    localparam logic [PARAM_W-1:0] SGR_NO_HIDDEN     = 16'd28;
    localparam logic [PARAM_W-1:0] SGR_NO_STRIKE     = 16'd29;
    localparam logic [PARAM_W-1:0] SGR_FG_LO         = 16'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_HI         = 16'd37;
    localparam logic [PARAM_W-1:0] SGR_FG_EXT        = 16'd38;
    localparam logic [PARAM_W-1:0] SGR_FG_DEFAULT    = 16'd39;
    localparam logic [PARAM_W-1:0] SGR_BG_LO         = 16'd40;
    localparam logic [PARAM_W-1:0] SGR_BG_HI         = 16'd47;
    localparam logic [PARAM_W-1:0] SGR_BG_EXT        = 16'd48;
    localparam logic [PARAM_W-1:0] SGR_BG_DEFAULT    = 16'd49;
    localparam logic [PARAM_W-1:0] SGR_FG_BRIGHT_LO  = 16'd90;
    localparam logic [PARAM_W-1:0] SGR_FG_BRIGHT_HI  = 16'd97;
    localparam logic [PARAM_W-1:0] SGR_BG_BRIGHT_LO  = 16'd100;
    localparam logic [PARAM_W-1:0] SGR_BG_BRIGHT_HI  = 16'd107;

    // Extended color selectors after 38/48
    localparam logic [PARAM_W-1:0] SEL_INDEXED = 16'd5;
    localparam logic [PARAM_W-1:0] SEL_RGB     = 16'd2;

    localparam logic [7:0] BRIGHT_BASE = 8'd8;

endpackage

`default_nettype wire

### rtl/sgrd_if.sv
// Valid/ready channel interfaces for the SGR attribute decoder.
// Depends on sgrd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sgrd_param_if;
    import sgrd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PARAM_W-1:0] param_value;
    logic               empty_list;
    logic               last_param;

    modport source (output valid, param_value, empty_list, last_param, input ready);
    modport sink   (input valid, param_value, empty_list, last_param, output ready);
endinterface

interface sgrd_attr_if;
    import sgrd_pkg::*;

    logic               valid;
    logic               ready;
    logic [ATTR_W-1:0]  attr_flags;
    logic [KIND_W-1:0]  fore_kind;
    logic [COLOR_W-1:0] fore_value;
    logic [KIND_W-1:0]  back_kind;
    logic [COLOR_W-1:0] back_value;
    logic               seq_done;

    modport source (output valid, attr_flags, fore_kind, fore_value, back_kind, back_value,
                    seq_done, input ready);
    modport sink   (input valid, attr_flags, fore_kind, fore_value, back_kind, back_value,
                    seq_done, output ready);
endinterface

`default_nettype wire

### rtl/sgr_attribute_decoder_top.sv
// SGR attribute decoder: input register, rendition state update, result register.
// Depends on sgrd_pkg and the channel interfaces in sgrd_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Decodes select-graphic-rendition parameters, one per transaction, and reports the
// current attribute flags, foreground and background colors and a sequence-done mark
// after every parameter. Throughput is one parameter per clock while the result side
// accepts; each parameter passes through the input register and then the result register,
// with the rendition state updated as the parameter leaves the input register. Both
// registers hold their contents while the result side stalls, and the input side keeps
// accepting as long as the pipeline can move. 38/48 extended color runs (5;n and 2;r;g;b)
// are committed only when complete.
module sgr_attribute_decoder_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sgrd_param_if.sink i_param,
    sgrd_attr_if.source o_attr
);
    import sgrd_pkg::*;

    // Input register
    logic               r_in_valid;
    logic [PARAM_W-1:0] r_in_param;
    logic               r_in_empty;
    logic               r_in_last;

    // Rendition state
    logic [ATTR_W-1:0]  r_attr,  n_attr;
    t_kind              r_fk,    n_fk;
    logic [COLOR_W-1:0] r_fv,    n_fv;
    t_kind              r_bk,    n_bk;
    logic [COLOR_W-1:0] r_bv,    n_bv;
    t_phase             r_phase, n_phase;
    logic               r_tback, n_tback;
    logic [7:0]         r_red,   n_red;
    logic [7:0]         r_green, n_green;
    logic               n_done;

    // Result register
    logic               r_out_valid;
    logic [ATTR_W-1:0]  r_out_attr;
    t_kind              r_out_fk;
    logic [COLOR_W-1:0] r_out_fv;
    t_kind              r_out_bk;
    logic [COLOR_W-1:0] r_out_bv;
    logic               r_out_done;

    logic       advance;
    logic       in_take;
    logic [7:0] p_low;

    assign advance        = r_in_valid && (!r_out_valid || o_attr.ready);
    assign in_take        = i_param.valid && i_param.ready;
    assign i_param.ready  = !r_in_valid || advance;
    assign p_low          = r_in_param[7:0];

    always_comb begin
        n_attr  = r_attr;
        n_fk    = r_fk;
        n_fv    = r_fv;
        n_bk    = r_bk;
        n_bv    = r_bv;
        n_phase = r_phase;
        n_tback = r_tback;
        n_red   = r_red;
        n_green = r_green;
        n_done  = 1'b1;

        if (r_in_empty) begin
            n_attr  = '0;
            n_fk    = KIND_DEFAULT;
            n_fv    = '0;
            n_bk    = KIND_DEFAULT;
            n_bv    = '0;
            n_phase = PH_IDLE;
        end else begin
            case (r_phase)
                PH_SEL: begin
                    if (r_in_param == SEL_INDEXED) begin
                        n_phase = PH_IDX;
                    end else if (r_in_param == SEL_RGB) begin
                        n_phase = PH_RED;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_IDX: begin
                    if (r_tback) begin
                        n_bk = KIND_INDEXED;
                        n_bv = {16'd0, p_low};
                    end else begin
                        n_fk = KIND_INDEXED;
                        n_fv = {16'd0, p_low};
                    end
                    n_phase = PH_IDLE;
                end
                PH_RED: begin
                    n_red   = p_low;
                    n_phase = PH_GREEN;
                end
                PH_GREEN: begin
                    n_green = p_low;
                    n_phase = PH_BLUE;
                end
                PH_BLUE: begin
                    if (r_tback) begin
                        n_bk = KIND_RGB;
                        n_bv = {r_red, r_green, p_low};
                    end else begin
                        n_fk = KIND_RGB;
                        n_fv = {r_red, r_green, p_low};
                    end
                    n_phase = PH_IDLE;
                end
                PH_SKIP: begin
                    // drop everything until the sequence ends
                end
                default: begin
                    n_phase = PH_IDLE;
                    case (r_in_param) inside
                        SGR_RESET: begin
                            n_attr = '0;
                            n_fk   = KIND_DEFAULT;
                            n_fv   = '0;
                            n_bk   = KIND_DEFAULT;
                            n_bv   = '0;
                        end
                        SGR_BOLD:          n_attr[ATTR_BOLD]      = 1'b1;
                        SGR_FAINT:         n_attr[ATTR_FAINT]     = 1'b1;
                        SGR_ITALIC:        n_attr[ATTR_ITALIC]    = 1'b1;
                        SGR_UNDERLINE:     n_attr[ATTR_UNDERLINE] = 1'b1;
                        SGR_BLINK:         n_attr[ATTR_BLINK]     = 1'b1;
                        SGR_REVERSE:       n_attr[ATTR_REVERSE]   = 1'b1;
                        SGR_HIDDEN:        n_attr[ATTR_HIDDEN]    = 1'b1;
                        SGR_STRIKE:        n_attr[ATTR_STRIKE]    = 1'b1;
                        SGR_NORMAL_WEIGHT: begin
                            n_attr[ATTR_BOLD]  = 1'b0;
                            n_attr[ATTR_FAINT] = 1'b0;
                        end
                        SGR_NO_ITALIC:     n_attr[ATTR_ITALIC]    = 1'b0;
                        SGR_NO_UNDERLINE:  n_attr[ATTR_UNDERLINE] = 1'b0;
                        SGR_NO_BLINK:      n_attr[ATTR_BLINK]     = 1'b0;
                        SGR_NO_REVERSE:    n_attr[ATTR_REVERSE]   = 1'b0;
                        SGR_NO_HIDDEN:     n_attr[ATTR_HIDDEN]    = 1'b0;
                        SGR_NO_STRIKE:     n_attr[ATTR_STRIKE]    = 1'b0;
                        SGR_FG_DEFAULT: begin
                            n_fk = KIND_DEFAULT;
                            n_fv = '0;
                        end
                        SGR_BG_DEFAULT: begin
                            n_bk = KIND_DEFAULT;
                            n_bv = '0;
                        end
                        SGR_FG_EXT: begin
                            n_tback = 1'b0;
                            n_phase = PH_SEL;
                        end
                        SGR_BG_EXT: begin
                            n_tback = 1'b1;
                            n_phase = PH_SEL;
                        end
                        [SGR_FG_LO:SGR_FG_HI]: begin
                            n_fk = KIND_INDEXED;
                            n_fv = {16'd0, p_low - SGR_FG_LO[7:0]};
                        end
                        [SGR_BG_LO:SGR_BG_HI]: begin
                            n_bk = KIND_INDEXED;
                            n_bv = {16'd0, p_low - SGR_BG_LO[7:0]};
                        end
                        [SGR_FG_BRIGHT_LO:SGR_FG_BRIGHT_HI]: begin
                            n_fk = KIND_INDEXED;
                            n_fv = {16'd0, p_low - SGR_FG_BRIGHT_LO[7:0] + BRIGHT_BASE};
                        end
                        [SGR_BG_BRIGHT_LO:SGR_BG_BRIGHT_HI]: begin
                            n_bk = KIND_INDEXED;
                            n_bv = {16'd0, p_low - SGR_BG_BRIGHT_LO[7:0] + BRIGHT_BASE};
                        end
                        default: begin
                            // unknown code: ignore
                        end
                    endcase
                end
            endcase
            n_done = r_in_last;
            // end of sequence: drop any pending run
            if (r_in_last) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_param.ready) begin
            r_in_valid <= i_param.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_param <= i_param.param_value;
            r_in_empty <= i_param.empty_list;
            r_in_last  <= i_param.last_param;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= '0;
            r_fk    <= KIND_DEFAULT;
            r_fv    <= '0;
            r_bk    <= KIND_DEFAULT;
            r_bv    <= '0;
            r_phase <= PH_IDLE;
            r_tback <= 1'b0;
            r_red   <= '0;
            r_green <= '0;
        end else if (advance) begin
            r_attr  <= n_attr;
            r_fk    <= n_fk;
            r_fv    <= n_fv;
            r_bk    <= n_bk;
            r_bv    <= n_bv;
            r_phase <= n_phase;
            r_tback <= n_tback;
            r_red   <= n_red;
            r_green <= n_green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_attr.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_attr <= n_attr;
            r_out_fk   <= n_fk;
            r_out_fv   <= n_fv;
            r_out_bk   <= n_bk;
            r_out_bv   <= n_bv;
            r_out_done <= n_done;
        end
    end

    assign o_attr.valid      = r_out_valid;
    assign o_attr.attr_flags = r_out_attr;
    assign o_attr.fore_kind  = r_out_fk;
    assign o_attr.fore_value = r_out_fv;
    assign o_attr.back_kind  = r_out_bk;
    assign o_attr.back_value = r_out_bv;
    assign o_attr.seq_done   = r_out_done;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for sgr_attribute_decoder_top: directed and random SGR sequences.
// Depends on sgrd_pkg, the channel interfaces in sgrd_if.sv and the decoder top level.
`timescale 1ns / 1ps

module tb_top;
    import sgrd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned RANDOM_ITEMS   = 1850;

    typedef struct packed {
        logic [ATTR_W-1:0]  attr_flags;
        t_kind              fore_kind;
        logic [COLOR_W-1:0] fore_value;
        t_kind              back_kind;
        logic [COLOR_W-1:0] back_value;
        logic               seq_done;
    } t_rendition;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sgrd_param_if u_param ();
    sgrd_attr_if  u_attr ();

    sgr_attribute_decoder_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_param (u_param),
        .o_attr  (u_attr)
    );

    always #5 clk = ~clk;

    // Predictor state
    logic [ATTR_W-1:0]  pred_attr = '0;
    t_kind              pred_fore_kind = KIND_DEFAULT;
    logic [COLOR_W-1:0] pred_fore_value = '0;
    t_kind              pred_back_kind = KIND_DEFAULT;
    logic [COLOR_W-1:0] pred_back_value = '0;
    t_phase             pred_phase = PH_IDLE;
    logic               pred_to_back = 1'b0;
    logic [7:0]         pred_red = '0;
    logic [7:0]         pred_green = '0;

    t_rendition expected_renditions[$];

    int unsigned error_count    = 0;
    int unsigned params_sent    = 0;
    int unsigned seqs_sent      = 0;
    int unsigned results_seen   = 0;
    int unsigned burst_left     = 0;
    int unsigned idle_cycles    = 0;

    task automatic clear_rendition();
        pred_attr       = '0;
        pred_fore_kind  = KIND_DEFAULT;
        pred_fore_value = '0;
        pred_back_kind  = KIND_DEFAULT;
        pred_back_value = '0;
    endtask

    task automatic set_ext_color(input t_kind kind, input logic [COLOR_W-1:0] value);
        if (pred_to_back) begin
            pred_back_kind  = kind;
            pred_back_value = value;
        end else begin
            pred_fore_kind  = kind;
            pred_fore_value = value;
        end
    endtask

    task automatic predict_rendition(input logic [PARAM_W-1:0] pv, input logic empty,
                                     input logic last, output t_rendition res);
        logic done;
        if (empty) begin
            clear_rendition();
            pred_phase = PH_IDLE;
            done = 1'b1;
        end else begin
            case (pred_phase)
                PH_SEL: begin
                    if (pv == SEL_INDEXED) pred_phase = PH_IDX;
                    else if (pv == SEL_RGB) pred_phase = PH_RED;
                    else pred_phase = PH_SKIP;
                end
                PH_IDX: begin
                    set_ext_color(KIND_INDEXED, {16'd0, pv[7:0]});
                    pred_phase = PH_IDLE;
                end
                PH_RED: begin
                    pred_red   = pv[7:0];
                    pred_phase = PH_GREEN;
                end
                PH_GREEN: begin
                    pred_green = pv[7:0];
                    pred_phase = PH_BLUE;
                end
                PH_BLUE: begin
                    set_ext_color(KIND_RGB, {pred_red, pred_green, pv[7:0]});
                    pred_phase = PH_IDLE;
                end
                PH_SKIP: ;
                default: begin
                    pred_phase = PH_IDLE;
                    case (pv)
                        SGR_RESET:         clear_rendition();
                        SGR_BOLD:          pred_attr[ATTR_BOLD] = 1'b1;
                        SGR_FAINT:         pred_attr[ATTR_FAINT] = 1'b1;
                        SGR_ITALIC:        pred_attr[ATTR_ITALIC] = 1'b1;
                        SGR_UNDERLINE:     pred_attr[ATTR_UNDERLINE] = 1'b1;
                        SGR_BLINK:         pred_attr[ATTR_BLINK] = 1'b1;
                        SGR_REVERSE:       pred_attr[ATTR_REVERSE] = 1'b1;
                        SGR_HIDDEN:        pred_attr[ATTR_HIDDEN] = 1'b1;
                        SGR_STRIKE:        pred_attr[ATTR_STRIKE] = 1'b1;
                        SGR_NORMAL_WEIGHT: begin
                            pred_attr[ATTR_BOLD]  = 1'b0;
                            pred_attr[ATTR_FAINT] = 1'b0;
                        end
                        SGR_NO_ITALIC:     pred_attr[ATTR_ITALIC] = 1'b0;
                        SGR_NO_UNDERLINE:  pred_attr[ATTR_UNDERLINE] = 1'b0;
                        SGR_NO_BLINK:      pred_attr[ATTR_BLINK] = 1'b0;
                        SGR_NO_REVERSE:    pred_attr[ATTR_REVERSE] = 1'b0;
                        SGR_NO_HIDDEN:     pred_attr[ATTR_HIDDEN] = 1'b0;
                        SGR_NO_STRIKE:     pred_attr[ATTR_STRIKE] = 1'b0;
                        SGR_FG_DEFAULT: begin
                            pred_fore_kind  = KIND_DEFAULT;
                            pred_fore_value = '0;
                        end
                        SGR_BG_DEFAULT: begin
                            pred_back_kind  = KIND_DEFAULT;
                            pred_back_value = '0;
                        end
                        SGR_FG_EXT: begin
                            pred_to_back = 1'b0;
                            pred_phase   = PH_SEL;
                        end
                        SGR_BG_EXT: begin
                            pred_to_back = 1'b1;
                            pred_phase   = PH_SEL;
                        end
                        default: begin
                            if (pv >= SGR_FG_LO && pv <= SGR_FG_HI) begin
                                pred_fore_kind  = KIND_INDEXED;
                                pred_fore_value = {16'd0, 8'(pv - SGR_FG_LO)};
                            end else if (pv >= SGR_BG_LO && pv <= SGR_BG_HI) begin
                                pred_back_kind  = KIND_INDEXED;
                                pred_back_value = {16'd0, 8'(pv - SGR_BG_LO)};
                            end else if (pv >= SGR_FG_BRIGHT_LO && pv <= SGR_FG_BRIGHT_HI) begin
                                pred_fore_kind  = KIND_INDEXED;
                                pred_fore_value = {16'd0, 8'(pv - SGR_FG_BRIGHT_LO) + BRIGHT_BASE};
                            end else if (pv >= SGR_BG_BRIGHT_LO && pv <= SGR_BG_BRIGHT_HI) begin
                                pred_back_kind  = KIND_INDEXED;
                                pred_back_value = {16'd0, 8'(pv - SGR_BG_BRIGHT_LO) + BRIGHT_BASE};
                            end
                        end
                    endcase
                end
            endcase
            done = last;
            if (last) pred_phase = PH_IDLE;
        end
        res.attr_flags = pred_attr;
        res.fore_kind  = pred_fore_kind;
        res.fore_value = pred_fore_value;
        res.back_kind  = pred_back_kind;
        res.back_value = pred_back_value;
        res.seq_done   = done;
    endtask

    // Send one parameter transaction; the sender sometimes idles between bursts of random length.
    task automatic send_param(input logic [PARAM_W-1:0] pv, input logic last,
                              input logic empty = 1'b0);
        int unsigned gap;
        t_rendition  res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                u_param.valid       = 1'b0;
                u_param.param_value = PARAM_W'($urandom);
                u_param.empty_list  = 1'($urandom);
                u_param.last_param  = 1'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        u_param.valid       = 1'b1;
        u_param.param_value = pv;
        u_param.empty_list  = empty;
        u_param.last_param  = last;
        do @(posedge clk); while (!u_param.ready);
        predict_rendition(pv, empty, last, res);
        expected_renditions.push_back(res);
        params_sent++;
        if (last || empty) seqs_sent++;
        burst_left--;
    endtask

    task automatic test_attribute_flags();
        send_param(SGR_BOLD, 1'b0);
        send_param(SGR_FAINT, 1'b0);
        send_param(SGR_ITALIC, 1'b0);
        send_param(SGR_UNDERLINE, 1'b0);
        send_param(SGR_BLINK, 1'b0);
        send_param(SGR_REVERSE, 1'b0);
        send_param(SGR_HIDDEN, 1'b0);
        send_param(SGR_STRIKE, 1'b1);
        send_param(SGR_NORMAL_WEIGHT, 1'b0);
        send_param(SGR_NO_ITALIC, 1'b0);
        send_param(SGR_NO_UNDERLINE, 1'b0);
        send_param(SGR_NO_BLINK, 1'b0);
        send_param(SGR_NO_REVERSE, 1'b0);
        send_param(SGR_NO_HIDDEN, 1'b0);
        send_param(SGR_NO_STRIKE, 1'b1);
    endtask

    task automatic test_indexed_colors();
        send_param(SGR_FG_HI, 1'b0);
        send_param(SGR_BG_BRIGHT_HI, 1'b0);
        send_param(SGR_FG_DEFAULT, 1'b0);
        send_param(SGR_FG_BRIGHT_LO, 1'b0);
        send_param(SGR_BG_DEFAULT, 1'b0);
        send_param(SGR_BG_LO, 1'b0);
        send_param(16'hFFFF, 1'b0);
        send_param(SGR_RESET, 1'b1);
    endtask

    task automatic test_extended_colors();
        // Index and color bytes keep only the low 8 bits
        send_param(SGR_FG_EXT, 1'b0);
        send_param(SEL_INDEXED, 1'b0);
        send_param(16'hFFFF, 1'b0);
        send_param(SGR_BG_EXT, 1'b0);
        send_param(SEL_RGB, 1'b0);
        send_param(16'h01FF, 1'b0);
        send_param(16'h0000, 1'b0);
        send_param(16'hAA55, 1'b1);
    endtask

    task automatic test_broken_runs();
        // Bad selector: the rest of the sequence is skipped
        send_param(SGR_FG_EXT, 1'b0);
        send_param(16'd3, 1'b0);
        send_param(SGR_BOLD, 1'b1);
        // Run cut short by the sequence end
        send_param(SGR_BG_EXT, 1'b0);
        send_param(SEL_RGB, 1'b0);
        send_param(16'd7, 1'b1);
        send_param(SGR_FG_EXT, 1'b1);
        // Empty list in the middle of a run
        send_param(SGR_UNDERLINE, 1'b0);
        send_param(SGR_BG_EXT, 1'b0);
        send_param(16'h5A5A, 1'b0, 1'b1);
        send_param(SGR_BG_BRIGHT_LO, 1'b1);
    endtask

    function automatic logic [PARAM_W-1:0] pick_plain_code();
        logic [PARAM_W-1:0] codes[20] = '{
            SGR_RESET, SGR_BOLD, SGR_FAINT, SGR_ITALIC, SGR_UNDERLINE, SGR_BLINK,
            SGR_REVERSE, SGR_HIDDEN, SGR_STRIKE, SGR_NORMAL_WEIGHT, SGR_NO_ITALIC,
            SGR_NO_UNDERLINE, SGR_NO_BLINK, SGR_NO_REVERSE, SGR_NO_HIDDEN,
            SGR_NO_STRIKE, SGR_FG_DEFAULT, SGR_BG_DEFAULT, SGR_BOLD, SGR_REVERSE
        };
        case ($urandom_range(0, 5))
            0: return SGR_FG_LO + PARAM_W'($urandom_range(0, 7));
            1: return SGR_BG_LO + PARAM_W'($urandom_range(0, 7));
            2: return SGR_FG_BRIGHT_LO + PARAM_W'($urandom_range(0, 7));
            3: return SGR_BG_BRIGHT_LO + PARAM_W'($urandom_range(0, 7));
            default: begin
                // Keep full resets rare so that state builds up
                if ($urandom_range(0, 9) == 0) return SGR_RESET;
                return codes[$urandom_range(1, 19)];
            end
        endcase
    endfunction

    task automatic test_random_sequences(input int unsigned target);
        logic [PARAM_W-1:0] seq[$];
        int unsigned        len;
        int unsigned        pick;
        int unsigned        stop_at;
        stop_at = params_sent + target;
        while (params_sent < stop_at) begin
            seq.delete();
            if ($urandom_range(0, 24) == 0) begin
                send_param(PARAM_W'($urandom), 1'($urandom), 1'b1);
                continue;
            end
            len = $urandom_range(1, 6);
            for (int unsigned i = 0; i < len; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    seq.push_back(pick_plain_code());
                end else if (pick < 75) begin
                    seq.push_back($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT);
                    if ($urandom_range(0, 1)) begin
                        seq.push_back(SEL_INDEXED);
                        seq.push_back(PARAM_W'($urandom));
                    end else begin
                        seq.push_back(SEL_RGB);
                        repeat (3) seq.push_back(PARAM_W'($urandom));
                    end
                end else if (pick < 82) begin
                    seq.push_back($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT);
                    seq.push_back($urandom_range(0, 1) ? PARAM_W'($urandom)
                                                       : PARAM_W'($urandom_range(0, 9)));
                end else if (pick < 90) begin
                    seq.push_back(PARAM_W'($urandom));
                end else begin
                    seq.push_back(PARAM_W'($urandom_range(0, 127)));
                end
            end
            // Cut some sequences short, often inside an extended run
            if (seq.size() > 1 && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) if (seq.size() > 1) void'(seq.pop_back());
            foreach (seq[i]) begin
                if ($urandom_range(0, 59) == 0)
                    send_param(PARAM_W'($urandom), 1'($urandom), 1'b1);
                send_param(seq[i], i == seq.size() - 1);
            end
        end
    endtask

    // Result checker
    always @(posedge clk) begin
        t_rendition exp_res;
        if (rst_n && u_attr.valid && u_attr.ready) begin
            results_seen++;
            if (expected_renditions.size() == 0) begin
                $error("unexpected result transaction with nothing outstanding");
                error_count++;
            end else begin
                exp_res = expected_renditions.pop_front();
                if (u_attr.attr_flags !== exp_res.attr_flags) begin
                    $error("attr_flags mismatch: expected %h, actual %h",
                           exp_res.attr_flags, u_attr.attr_flags);
                    error_count++;
                end
                if (u_attr.fore_kind !== exp_res.fore_kind) begin
                    $error("fore_kind mismatch: expected %0d, actual %0d",
                           exp_res.fore_kind, u_attr.fore_kind);
                    error_count++;
                end
                if (u_attr.fore_value !== exp_res.fore_value) begin
                    $error("fore_value mismatch: expected %h, actual %h",
                           exp_res.fore_value, u_attr.fore_value);
                    error_count++;
                end
                if (u_attr.back_kind !== exp_res.back_kind) begin
                    $error("back_kind mismatch: expected %0d, actual %0d",
                           exp_res.back_kind, u_attr.back_kind);
                    error_count++;
                end
                if (u_attr.back_value !== exp_res.back_value) begin
                    $error("back_value mismatch: expected %h, actual %h",
                           exp_res.back_value, u_attr.back_value);
                    error_count++;
                end
                if (u_attr.seq_done !== exp_res.seq_done) begin
                    $error("seq_done mismatch: expected %0d, actual %0d",
                           exp_res.seq_done, u_attr.seq_done);
                    error_count++;
                end
            end
        end
    end

    // Result-side backpressure: switch between several stall patterns
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned stall_left;
        int unsigned cyc;
        u_attr.ready = 1'b0;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        cyc = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            case (mode)
                0: u_attr.ready = 1'b1;
                1: u_attr.ready = ($urandom_range(0, 9) < 7);
                2: u_attr.ready = ((cyc % 7) < 4);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        u_attr.ready = 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(5, 40);
                        u_attr.ready = 1'b0;
                    end else begin
                        u_attr.ready = 1'b1;
                    end
                end
            endcase
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if ((u_param.valid && u_param.ready) || (u_attr.valid && u_attr.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        u_param.valid       = 1'b0;
        u_param.param_value = '0;
        u_param.empty_list  = 1'b0;
        u_param.last_param  = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_attribute_flags();
        test_indexed_colors();
        test_extended_colors();
        test_broken_runs();
        test_random_sequences(RANDOM_ITEMS);

        @(negedge clk);
        u_param.valid = 1'b0;
        while (expected_renditions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d parameters in %0d sequences, checked %0d results",
                 params_sent, seqs_sent, results_seen);
        $display("Covered flags, indexed and extended colors, broken runs and empty lists");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sgrd_pkg.sv
rtl/sgrd_if.sv
rtl/sgr_attribute_decoder_top.sv
tb/tb_top.sv
